### design/gtf_pkg.sv
// Shared types and constants for the grouped FIFO ("team queue").
// Used by the top level and by the port checker; no other dependencies.
`timescale 1ns / 1ps

package gtf_pkg;

	// Fixed field widths of the command and result words.
	localparam int ELEM_W       = 20;
	localparam int GROUP_W      = 4;
	localparam int NUM_GROUPS_W = 5;
	localparam int STATUS_W     = 2;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_GROUPS = 16;
	localparam int DEF_SUB_DEPTH  = 16;
	localparam int DEF_ELEM_BITS  = 20;

	// Reset value of the ring size register.
	localparam logic [NUM_GROUPS_W-1:0] NUM_GROUPS_RST = 5'd16;

	// Operation codes carried by func.
	typedef enum logic {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_DROPPED = 2'd2
	} status_t;

endpackage

### design/gtf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for the element storage of the grouped FIFO.
`timescale 1ns / 1ps

module gtf_ram #(
	parameter int WIDTH = 20,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/grouped_team_fifo.sv
// Grouped FIFO ("team queue") top level: slot ring control and element storage.
// Depends on gtf_pkg and gtf_ram.
`timescale 1ns / 1ps

// One command word (enqueue or dequeue) is taken in every clock cycle; busy is
// always low. Each command produces exactly one result word, shown on the result
// ports with done high for one cycle, after the command has passed the command
// register and then the result register, which is loaded as the slot ring is
// updated and the element storage is read. Results cannot be stalled. The ring
// size register may be written only while no command is in flight.
module grouped_team_fifo #(
	parameter int MAX_GROUPS = gtf_pkg::DEF_MAX_GROUPS,
	parameter int SUB_DEPTH  = gtf_pkg::DEF_SUB_DEPTH,
	parameter int ELEM_BITS  = gtf_pkg::DEF_ELEM_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration port.
	input  logic                            cfg_we,
	input  logic [gtf_pkg::NUM_GROUPS_W-1:0] cfg_wdata,
	// Command port.
	input  logic                            start,
	output logic                            busy,
	input  logic                            func,
	input  logic [gtf_pkg::ELEM_W-1:0]      element,
	input  logic [gtf_pkg::GROUP_W-1:0]     group,
	// Result port.
	output logic                            done,
	output logic [gtf_pkg::STATUS_W-1:0]    status,
	output logic [gtf_pkg::ELEM_W-1:0]      out_element,
	output logic                            out_valid
);

	localparam int SLOT_W    = $clog2(MAX_GROUPS);
	localparam int POS_W     = $clog2(SUB_DEPTH);
	localparam int CNT_W     = $clog2(SUB_DEPTH + 1);
	localparam int TOT_W     = $clog2(MAX_GROUPS * SUB_DEPTH + 1);
	localparam int EFF_W     = $clog2(MAX_GROUPS + 1);
	localparam int ADDR_W    = SLOT_W + POS_W;
	localparam int RAM_DEPTH = 2 ** ADDR_W;

	// Ring size register.
	logic [gtf_pkg::NUM_GROUPS_W-1:0] num_groups_q;

	// Command stage.
	logic                        start_s1;
	logic                        func_s1;
	logic [gtf_pkg::ELEM_W-1:0]  element_s1;
	logic [gtf_pkg::GROUP_W-1:0] group_s1;

	// Result stage.
	logic                          done_s2;
	logic [gtf_pkg::STATUS_W-1:0]  status_s2;
	logic                          valid_s2;
	logic [ELEM_BITS-1:0]          rdata;

	// Group map and per-slot state.
	logic              map_valid_q  [MAX_GROUPS];
	logic [SLOT_W-1:0] map_slot_q   [MAX_GROUPS];
	logic [POS_W-1:0]  slot_head_q  [MAX_GROUPS];
	logic [CNT_W-1:0]  slot_cnt_q   [MAX_GROUPS];
	logic [SLOT_W-1:0] slot_owner_q [MAX_GROUPS];
	logic [SLOT_W-1:0] head_slot_q;
	logic [SLOT_W-1:0] tail_slot_q;
	logic [TOT_W-1:0]  total_q;

	// Decode of the command in stage 1.
	logic [EFF_W-1:0]           eff;
	logic [gtf_pkg::GROUP_W-1:0] gmod;
	logic [SLOT_W-1:0]          g_idx;
	logic                       is_enq;
	logic                       hit;
	logic [SLOT_W-1:0]          sel_slot;
	logic [CNT_W-1:0]           sel_cnt;
	logic [POS_W-1:0]           sel_hp;
	logic [POS_W-1:0]           hp_inc;
	logic [CNT_W:0]             pos_sum;
	logic [POS_W-1:0]           wr_pos;
	logic [SLOT_W-1:0]          nxt_slot;
	logic [SLOT_W:0]            slot_plus;
	logic                       enq_ok;
	logic                       deq_ok;
	logic                       deq_empty;
	logic                       drain;
	logic [gtf_pkg::STATUS_W-1:0] status_d;

	// Every command is taken at once.
	assign busy = 1'b0;

	// Ring size register; the user must write it only while idle, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_groups_q <= gtf_pkg::NUM_GROUPS_RST;
		end else if (cfg_we) begin
			num_groups_q <= cfg_wdata;
		end
	end

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_s1 <= 1'b0;
		end else begin
			start_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			func_s1    <= func;
			element_s1 <= element;
			group_s1   <= group;
		end
	end

	// Effective ring size: zero acts as one, large values clamp to the table size.
	always_comb begin
		if (num_groups_q == '0) begin
			eff = EFF_W'(1);
		end else if (32'(num_groups_q) > MAX_GROUPS) begin
			eff = EFF_W'(MAX_GROUPS);
		end else begin
			eff = EFF_W'(num_groups_q);
		end
	end

	// Group id folded into the table by repeated subtraction (a few steps at most).
	always_comb begin
		gmod = group_s1;
		for (int i = 0; i < 8; i++) begin
			if (32'(gmod) >= MAX_GROUPS) begin
				gmod = gmod - gtf_pkg::GROUP_W'(MAX_GROUPS);
			end
		end
		g_idx = SLOT_W'(gmod);
	end

	// Slot selection and the decisions for this command.
	always_comb begin
		is_enq   = (func_s1 == gtf_pkg::FUNC_ENQ);
		hit      = map_valid_q[g_idx];
		if (!is_enq) begin
			sel_slot = head_slot_q;
		end else if (hit) begin
			sel_slot = map_slot_q[g_idx];
		end else begin
			sel_slot = tail_slot_q;
		end
		sel_cnt = slot_cnt_q[sel_slot];
		sel_hp  = slot_head_q[sel_slot];

		// Next slot around the ring; an out-of-range pointer wraps to zero.
		slot_plus = {1'b0, sel_slot} + (SLOT_W + 1)'(1);
		if (slot_plus >= (SLOT_W + 1)'(eff)) begin
			nxt_slot = '0;
		end else begin
			nxt_slot = SLOT_W'(slot_plus);
		end

		// Write position behind the last queued element, wrapped once; zero for a new group.
		pos_sum = (CNT_W + 1)'(sel_hp) + (CNT_W + 1)'(sel_cnt);
		if (pos_sum >= (CNT_W + 1)'(SUB_DEPTH)) begin
			pos_sum = pos_sum - (CNT_W + 1)'(SUB_DEPTH);
		end
		wr_pos = hit ? POS_W'(pos_sum) : '0;

		// Front pointer after a pop.
		if (32'(sel_hp) == SUB_DEPTH - 1) begin
			hp_inc = '0;
		end else begin
			hp_inc = sel_hp + POS_W'(1);
		end

		if (hit) begin
			enq_ok = is_enq && (sel_cnt != CNT_W'(SUB_DEPTH));
		end else begin
			enq_ok = is_enq && (sel_cnt == '0);
		end
		deq_ok    = !is_enq && (sel_cnt != '0);
		deq_empty = !is_enq && (sel_cnt == '0);
		drain     = deq_ok && (sel_cnt == CNT_W'(1));

		if (is_enq && !enq_ok) begin
			status_d = gtf_pkg::ST_DROPPED;
		end else if (deq_empty) begin
			status_d = gtf_pkg::ST_EMPTY;
		end else begin
			status_d = gtf_pkg::ST_OK;
		end
	end

	// Map, slot and ring pointer updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_GROUPS; i++) begin
				map_valid_q[i]  <= 1'b0;
				map_slot_q[i]   <= '0;
				slot_head_q[i]  <= '0;
				slot_cnt_q[i]   <= '0;
				slot_owner_q[i] <= '0;
			end
			head_slot_q <= '0;
			tail_slot_q <= '0;
			total_q     <= '0;
		end else if (start_s1) begin
			if (enq_ok) begin
				slot_cnt_q[sel_slot] <= sel_cnt + CNT_W'(1);
				total_q              <= total_q + TOT_W'(1);
				if (!hit) begin
					slot_head_q[sel_slot]  <= '0;
					slot_owner_q[sel_slot] <= g_idx;
					map_valid_q[g_idx]     <= 1'b1;
					map_slot_q[g_idx]      <= sel_slot;
					tail_slot_q            <= nxt_slot;
				end
			end
			if (deq_ok) begin
				slot_head_q[sel_slot] <= hp_inc;
				slot_cnt_q[sel_slot]  <= sel_cnt - CNT_W'(1);
				total_q               <= total_q - TOT_W'(1);
				if (drain) begin
					map_valid_q[slot_owner_q[sel_slot]] <= 1'b0;
					head_slot_q                         <= nxt_slot;
				end
			end
			// An empty head slot is skipped while other slots still hold words.
			if (deq_empty && (total_q != '0)) begin
				head_slot_q <= nxt_slot;
			end
		end
	end

	// Element storage, addressed by slot and position.
	gtf_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (start_s1 && enq_ok),
		.waddr ({sel_slot, wr_pos}),
		.wdata (ELEM_BITS'(element_s1)),
		.re    (start_s1 && deq_ok),
		.raddr ({sel_slot, sel_hp}),
		.rdata (rdata)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			done_s2  <= start_s1;
			valid_s2 <= start_s1 && deq_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (start_s1) begin
			status_s2 <= status_d;
		end
	end

	// Result ports; the element reads as zero unless a word was popped.
	assign done        = done_s2;
	assign status      = status_s2;
	assign out_valid   = valid_s2;
	assign out_element = valid_s2 ? gtf_pkg::ELEM_W'(rdata) : '0;

endmodule

### design/gtf_checker.sv
// Port-level checker for the grouped FIFO, bound to the top level.
// Depends on gtf_pkg and on the ports of grouped_team_fifo.
`timescale 1ns / 1ps

module gtf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         func,
	input logic                         done,
	input logic [gtf_pkg::STATUS_W-1:0] status,
	input logic [gtf_pkg::ELEM_W-1:0]   out_element,
	input logic                         out_valid
);

	// Every accepted command is answered by a result word.
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted command produced no result");

	// A result only appears for a command that was taken earlier.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a command");

	// A popped word comes only from a dequeue and carries an ok status.
	a_valid_deq: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (done && status == gtf_pkg::ST_OK
			&& $past(func, 2) == gtf_pkg::FUNC_DEQ))
		else $error("popped word without a successful dequeue");

	// An empty report belongs to a dequeue, a drop to an enqueue.
	a_status_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_valid) |-> ((status == gtf_pkg::ST_EMPTY
			&& $past(func, 2) == gtf_pkg::FUNC_DEQ && out_element == '0)
			|| (status == gtf_pkg::ST_DROPPED && $past(func, 2) == gtf_pkg::FUNC_ENQ
			&& out_element == '0)
			|| (status == gtf_pkg::ST_OK && $past(func, 2) == gtf_pkg::FUNC_ENQ
			&& out_element == '0)))
		else $error("status does not match the command");

endmodule

bind grouped_team_fifo gtf_checker u_gtf_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the grouped FIFO (team queue) top level.
// Depends on gtf_pkg and grouped_team_fifo; a class-based scoreboard predicts each result.
`timescale 1ns / 1ps

module tb;
	import gtf_pkg::*;

	localparam int NGRP       = DEF_MAX_GROUPS;
	localparam int DEPTH      = DEF_SUB_DEPTH;
	localparam int STALL_MAX  = 2000;
	localparam int GAP_MAX    = 60;
	localparam int PHASE_ITEMS = 220;

	typedef struct {
		status_t           st;
		logic [ELEM_W-1:0] elem;
		logic              valid;
	} result_word_t;

	// Scoreboard: keeps its own copy of the slot ring and the words still owed by the block.
	class ring_model;
		bit [NUM_GROUPS_W-1:0] ring_size;
		bit                    map_valid[NGRP];
		bit [3:0]              map_slot[NGRP];
		bit [ELEM_W-1:0]       store[NGRP][DEPTH];
		bit [3:0]              head_ptr[NGRP];
		bit [4:0]              fill[NGRP];
		bit [3:0]              owner[NGRP];
		bit [3:0]              head_slot;
		bit [3:0]              tail_slot;
		bit [8:0]              total;
		result_word_t          owed_words[$];
		int                    fails;
		int                    n_cmds, n_popped, n_empty, n_dropped;

		function new();
			ring_size = NUM_GROUPS_RST;
			for (int i = 0; i < NGRP; i++) begin
				map_valid[i] = 0;
				map_slot[i]  = '0;
				head_ptr[i]  = '0;
				fill[i]      = '0;
				owner[i]     = '0;
			end
			head_slot = '0;
			tail_slot = '0;
			total     = '0;
			fails     = 0;
			n_cmds    = 0;
			n_popped  = 0;
			n_empty   = 0;
			n_dropped = 0;
		endfunction

		function void set_ring_size(bit [NUM_GROUPS_W-1:0] v);
			ring_size = v;
		endfunction

		// Zero behaves as one slot; anything above the table size uses the whole table.
		function int live_slots();
			if (ring_size == 0) return 1;
			if (ring_size > NGRP) return NGRP;
			return int'(ring_size);
		endfunction

		function bit [3:0] next_slot(bit [3:0] s);
			int n;
			n = int'(s) + 1;
			return (n >= live_slots()) ? 4'd0 : n[3:0];
		endfunction

		function bit push_elem(bit [3:0] s, bit [ELEM_W-1:0] v);
			bit [3:0] pos;
			if (fill[s] >= DEPTH) return 0;
			pos = head_ptr[s] + fill[s][3:0];
			store[s][pos] = v;
			fill[s]++;
			total++;
			return 1;
		endfunction

		function result_word_t predict_word(func_t f, bit [ELEM_W-1:0] e, bit [GROUP_W-1:0] g);
			result_word_t r;
			bit [3:0]     s;
			r.st    = ST_OK;
			r.elem  = '0;
			r.valid = 1'b0;
			if (f == FUNC_ENQ) begin
				if (map_valid[g]) begin
					if (!push_elem(map_slot[g], e)) r.st = ST_DROPPED;
				end else begin
					s = tail_slot;
					// A group that is not queued needs the tail slot to be free.
					if (fill[s] != 0) begin
						r.st = ST_DROPPED;
					end else begin
						head_ptr[s] = '0;
						void'(push_elem(s, e));
						owner[s]     = g;
						map_valid[g] = 1;
						map_slot[g]  = s;
						tail_slot    = next_slot(s);
					end
				end
			end else begin
				s = head_slot;
				if (fill[s] == 0) begin
					// Empty head slot; skip ahead when stranded slots still hold data.
					r.st = ST_EMPTY;
					if (total != 0) head_slot = next_slot(s);
				end else begin
					r.elem      = store[s][head_ptr[s]];
					r.valid     = 1'b1;
					head_ptr[s] = head_ptr[s] + 4'd1;
					fill[s]--;
					total--;
					if (fill[s] == 0) begin
						map_valid[owner[s]] = 0;
						head_slot = next_slot(s);
					end
				end
			end
			return r;
		endfunction

		function void note_command(func_t f, logic [ELEM_W-1:0] e, logic [GROUP_W-1:0] g);
			result_word_t r;
			r = predict_word(f, e, g);
			n_cmds++;
			if (r.valid) n_popped++;
			if (r.st == ST_EMPTY) n_empty++;
			if (r.st == ST_DROPPED) n_dropped++;
			owed_words = {owed_words, r};
		endfunction

		function void check_word(logic [STATUS_W-1:0] st, logic [ELEM_W-1:0] el, logic v);
			result_word_t r;
			if (owed_words.size() == 0) begin
				$error("result word with nothing expected: status=%0d out_element=%0h out_valid=%0b",
					st, el, v);
				fails++;
				return;
			end
			r = owed_words.pop_front();
			if (st !== r.st) begin
				$error("status: expected %0d, actual %0d", r.st, st);
				fails++;
			end
			if (el !== r.elem) begin
				$error("out_element: expected %0h, actual %0h", r.elem, el);
				fails++;
			end
			if (v !== r.valid) begin
				$error("out_valid: expected %0b, actual %0b", r.valid, v);
				fails++;
			end
		endfunction

		function int pending();
			return owed_words.size();
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [NUM_GROUPS_W-1:0] cfg_wdata;
	logic                    start;
	logic                    busy;
	logic                    func;
	logic [ELEM_W-1:0]       element;
	logic [GROUP_W-1:0]      group;
	logic                    done;
	logic [STATUS_W-1:0]     status;
	logic [ELEM_W-1:0]       out_element;
	logic                    out_valid;

	ring_model model;
	int        stall_cycles;

	grouped_team_fifo dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.element    (element),
		.group      (group),
		.done       (done),
		.status     (status),
		.out_element(out_element),
		.out_valid  (out_valid)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Monitor: note accepted command words, check result words, and run the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) model.note_command(func_t'(func), element, group);
			if (done) model.check_word(status, out_element, out_valid);
			if ((start && !busy) || done) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
			if (stall_cycles >= STALL_MAX) begin
				$display("watchdog: %0d cycles without a word moving", stall_cycles);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Present one command word and hold it until the block takes it.
	task automatic send_word(input func_t f, input logic [ELEM_W-1:0] e,
		input logic [GROUP_W-1:0] g);
		start   <= 1'b1;
		func    <= f;
		element <= e;
		group   <= g;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// Random idle cycles between command words.
	task automatic sender_gaps(input int pct);
		int n;
		n = 0;
		while (n < GAP_MAX && $urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
			n++;
		end
	endtask

	// Stop sending and wait until every owed result word has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (model.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ring_size(input logic [NUM_GROUPS_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model.set_ring_size(v);
	endtask

	// Bursts lean toward filling or toward draining; groups mostly come from a small pool.
	task automatic random_phase(input int items, input int pct);
		int                burst_left;
		int                enq_pct;
		int                base;
		int                pick;
		func_t             f;
		logic [ELEM_W-1:0] e;
		logic [GROUP_W-1:0] g;
		burst_left = 0;
		enq_pct    = 70;
		base       = 0;
		for (int i = 0; i < items; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(60, 20);
				enq_pct    = (enq_pct == 70) ? 35 : 70;
				base       = $urandom_range(NGRP - 1);
			end
			burst_left--;
			f = ($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
			pick = $urandom_range(99);
			if (pick < 10) begin
				e = '0;
			end else if (pick < 20) begin
				e = '1;
			end else begin
				e = ELEM_W'($urandom_range((1 << ELEM_W) - 1));
			end
			if ($urandom_range(99) < 65) begin
				g = GROUP_W'(base + $urandom_range(3));
			end else begin
				g = GROUP_W'($urandom_range(NGRP - 1));
			end
			sender_gaps(pct);
			send_word(f, e, g);
		end
	endtask

	initial begin
		logic [NUM_GROUPS_W-1:0] sizes[9];
		int                      idle_pct;
		sizes        = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd2, 5'd16, 5'd3, 5'd8};
		model        = new();
		stall_cycles = 0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		start        = 1'b0;
		func         = 1'b0;
		element      = '0;
		group        = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset ring size: empty pop, field extremes, joining, full sub-queue.
		send_word(FUNC_DEQ, '1, '1);
		send_word(FUNC_ENQ, '0, 4'd0);
		send_word(FUNC_ENQ, '1, 4'd15);
		send_word(FUNC_ENQ, 20'h5A5A5, 4'd0);
		sender_gaps(6);
		send_word(FUNC_DEQ, '0, '0);
		send_word(FUNC_DEQ, '0, '0);
		send_word(FUNC_DEQ, '0, '0);
		send_word(FUNC_DEQ, '0, '0);
		for (int i = 0; i <= DEPTH; i++) begin
			send_word(FUNC_ENQ, ELEM_W'(20'hA0000 + i), 4'd7);
		end

		// Random phases; the queue is left populated across ring size changes.
		for (int p = 0; p < 9; p++) begin
			write_ring_size(sizes[p]);
			idle_pct = (p < 3) ? 6 : ((p < 6) ? 82 : 0);
			random_phase(PHASE_ITEMS, idle_pct);
		end

		drain_results();
		if (model.pending() != 0) begin
			$error("%0d result words never arrived", model.pending());
			model.fails++;
		end
		$display("Covered %0d commands over ring sizes 16,1,5,0,31,2,16,3,8.", model.n_cmds);
		$display("Words popped %0d, empty pops %0d, dropped pushes %0d.",
			model.n_popped, model.n_empty, model.n_dropped);
		if (model.fails == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
